// ===== rtl/psaw_pkg.sv =====
// Package: shared widths, constants and state types for the PID anti-windup block.
`default_nettype none

package psaw_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned LIM_W       = 31;
  localparam int unsigned CFG_IDX_W   = 3;

  localparam int unsigned MAC_A_W     = 48;
  localparam int unsigned MAC_B_W     = 32;
  localparam int unsigned MAC_CHUNK_W = 16;
  localparam int unsigned MAC_P_W     = MAC_A_W + MAC_CHUNK_W;
  localparam int unsigned MAC_R_W     = MAC_A_W + MAC_B_W;

  localparam int unsigned DIV_N_W     = 65;
  localparam int unsigned DIV_Q_W     = 49;
  localparam int unsigned DIV_CNT_W   = 6;

  localparam int unsigned MAG_W       = DATA_W + 1;
  localparam int unsigned PMAG_W      = 47;
  localparam int unsigned IMAG_W      = 41;
  localparam int unsigned IRAW_W      = 42;
  localparam int unsigned PI_W        = 49;
  localparam int unsigned TOT_W       = 51;

  // integral step saturates at 2^40, derivative at 2^48
  localparam logic [IMAG_W-1:0]  I_CAP = {1'b1, {(IMAG_W-1){1'b0}}};
  localparam logic [DIV_Q_W-1:0] D_CAP = {1'b1, {(DIV_Q_W-1){1'b0}}};

  localparam logic [CFG_IDX_W-1:0] CFG_P_GAIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_I_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_D_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 3'd4;

  localparam logic [DATA_W-1:0] PERIOD_RST = 32'd262;
  localparam logic [LIM_W-1:0]  LIMIT_RST  = 31'd26214400;

  typedef enum logic [1:0] {
    MAC_IDLE,
    MAC_LO,
    MAC_HI,
    MAC_ACC
  } mac_ph_e;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_FIN
  } div_st_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_D_START,
    S_D_WAIT,
    S_P_WAIT,
    S_I1_WAIT,
    S_I2_WAIT,
    S_I_CLAMP,
    S_SUM1,
    S_DIV_WAIT,
    S_SUM2,
    S_OUT
  } seq_st_e;

endpackage

`default_nettype wire

// ===== rtl/psaw_mac.sv =====
// Shared multiplier: 48 x 32 unsigned product built from two 48 x 16 partial products.
`default_nettype none

module psaw_mac (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [psaw_pkg::MAC_A_W-1:0]  a_i,
  input  wire logic [psaw_pkg::MAC_B_W-1:0]  b_i,
  output logic                               busy_o,
  output logic      [psaw_pkg::MAC_R_W-1:0]  res_o
);
  import psaw_pkg::*;

  mac_ph_e                 ph_q, ph_d;
  logic [MAC_A_W-1:0]      a_q;
  logic [MAC_B_W-1:0]      b_q;
  logic [MAC_CHUNK_W-1:0]  chunk;
  logic [MAC_P_W-1:0]      prod_q, prod_d;
  logic [MAC_R_W-1:0]      acc_q, acc_d;

  always_comb begin
    unique case (ph_q)
      MAC_IDLE: ph_d = start_i ? MAC_LO : MAC_IDLE;
      MAC_LO:   ph_d = MAC_HI;
      MAC_HI:   ph_d = MAC_ACC;
      MAC_ACC:  ph_d = MAC_IDLE;
      default:  ph_d = MAC_IDLE;
    endcase
  end

  always_comb begin
    chunk  = (ph_q == MAC_HI) ? b_q[MAC_B_W-1:MAC_CHUNK_W] : b_q[MAC_CHUNK_W-1:0];
    prod_d = MAC_P_W'(a_q) * MAC_P_W'(chunk);
    acc_d  = acc_q;
    unique case (ph_q)
      MAC_HI:  acc_d = MAC_R_W'(prod_q);
      MAC_ACC: acc_d = acc_q + {prod_q, {MAC_CHUNK_W{1'b0}}};
      default: acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= MAC_IDLE;
    end else begin
      ph_q <= ph_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && (ph_q == MAC_IDLE)) begin
      a_q <= a_i;
      b_q <= b_i;
    end
    prod_q <= prod_d;
    acc_q  <= acc_d;
  end

  assign busy_o = (ph_q != MAC_IDLE);
  assign res_o  = acc_q;

endmodule

`default_nettype wire

// ===== rtl/psaw_div.sv =====
// Restoring divider, one quotient bit per cycle, quotient saturated at 2^48.
`default_nettype none

module psaw_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [psaw_pkg::DIV_N_W-1:0]  num_i,
  input  wire logic [psaw_pkg::DATA_W-1:0]   den_i,
  output logic                               busy_o,
  output logic      [psaw_pkg::DIV_Q_W-1:0]  quo_o
);
  import psaw_pkg::*;

  localparam int unsigned TOP_W = DIV_N_W - DIV_Q_W;

  div_st_e               st_q, st_d;
  logic [DATA_W-1:0]     den_q, den_d;
  logic [DATA_W-1:0]     rem_q, rem_d;
  logic [DIV_Q_W-1:0]    num_q, num_d;
  logic [DIV_Q_W-1:0]    quo_q, quo_d;
  logic [DIV_Q_W-1:0]    res_q, res_d;
  logic [DIV_CNT_W-1:0]  cnt_q, cnt_d;
  logic [TOP_W-1:0]      num_top;
  logic                  num_zero;
  logic                  sat;
  logic [DATA_W:0]       rem_sh;
  logic                  ge;

  assign num_top  = num_i[DIV_N_W-1:DIV_Q_W];
  assign num_zero = (num_i == '0);
  // quotient would reach 2^49 or more; also covers a zero divisor
  assign sat      = (DATA_W'(num_top) >= den_i);

  always_comb begin
    unique case (st_q)
      DIV_IDLE: st_d = (start_i && !num_zero && !sat) ? DIV_RUN : DIV_IDLE;
      DIV_RUN:  st_d = (cnt_q == '0) ? DIV_FIN : DIV_RUN;
      DIV_FIN:  st_d = DIV_IDLE;
      default:  st_d = DIV_IDLE;
    endcase
  end

  always_comb begin
    rem_sh = {rem_q, num_q[DIV_Q_W-1]};
    ge     = (rem_sh >= {1'b0, den_q});
    den_d  = den_q;
    rem_d  = rem_q;
    num_d  = num_q;
    quo_d  = quo_q;
    res_d  = res_q;
    cnt_d  = cnt_q;
    unique case (st_q)
      DIV_IDLE: begin
        if (start_i) begin
          den_d = den_i;
          rem_d = DATA_W'(num_top);
          num_d = num_i[DIV_Q_W-1:0];
          cnt_d = DIV_CNT_W'(DIV_Q_W - 1);
          if (num_zero) begin
            res_d = '0;
          end else if (sat) begin
            res_d = D_CAP;
          end
        end
      end
      DIV_RUN: begin
        rem_d = ge ? DATA_W'(rem_sh - {1'b0, den_q}) : rem_sh[DATA_W-1:0];
        num_d = {num_q[DIV_Q_W-2:0], 1'b0};
        quo_d = {quo_q[DIV_Q_W-2:0], ge};
        cnt_d = cnt_q - 1'b1;
      end
      DIV_FIN: begin
        res_d = (quo_q[DIV_Q_W-1] && (|quo_q[DIV_Q_W-2:0])) ? D_CAP : quo_q;
      end
      default: res_d = res_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= DIV_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    den_q <= den_d;
    rem_q <= rem_d;
    num_q <= num_d;
    quo_q <= quo_d;
    res_q <= res_d;
    cnt_q <= cnt_d;
  end

  assign busy_o = (st_q != DIV_IDLE);
  assign quo_o  = res_q;

endmodule

`default_nettype wire

// ===== rtl/pid_step_antiwindup.sv =====
// Top level: PID channel with clamped trapezoidal integral, sequencer and output register.
//
// One control error arrives per transaction on the input channel (in_valid_i / in_stall_o,
// fields error_value_i, clear_after_i). One result leaves per input transaction on the
// output channel (out_valid_o / out_stall_i, fields drive_o, integral_term_o,
// output_clamped_o). Gains, sample period and clamp limit are written through the
// cfg_we_i / cfg_index_i / cfg_data_i port; the user must write them only while the
// block is idle, which the block itself does not enforce. The 49-step restoring
// divider for the derivative term sets the time from input transaction to result
// valid; when its quotient is zero or saturates at once, the shared 48x16 multiplier
// sequence (four products) sets it instead. in_stall_o is high while an item is in
// work, so a new transaction is taken only once the sequencer is done with the last.
// The result sits in an output register: a new item is taken while it waits. If the
// receiver stalls, the next result waits in the sequencer until the register frees.
// Reset loads the default configuration, zeroes the stored error and integral and
// empties the output register.
`default_nettype none

module pid_step_antiwindup (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [psaw_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [psaw_pkg::DATA_W-1:0]     cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic signed [psaw_pkg::DATA_W-1:0] error_value_i,
  input  wire logic                            clear_after_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic signed [psaw_pkg::DATA_W-1:0]   drive_o,
  output logic signed [psaw_pkg::DATA_W-1:0]   integral_term_o,
  output logic                                 output_clamped_o
);
  import psaw_pkg::*;

  // configuration
  logic [DATA_W-1:0] p_gain_q, i_gain_q, d_gain_q, period_q;
  logic [LIM_W-1:0]  lim_q;

  // sequencer
  seq_st_e st_q, st_d;
  logic    in_acc;
  logic    out_load;

  // item and channel state
  logic signed [DATA_W-1:0] e_q;
  logic                     clr_q;
  logic signed [DATA_W-1:0] last_q, iacc_q;

  // working registers
  logic [PMAG_W-1:0]        pmag_q, pmag_d;
  logic [IMAG_W-1:0]        imag_q, imag_d;
  logic signed [DATA_W-1:0] iterm_q, iterm_d;
  logic signed [PI_W-1:0]   pi_q, pi_d;
  logic signed [TOT_W-1:0]  tot_q, tot_d;

  // output register
  logic                     out_valid_q, out_valid_d;
  logic signed [DATA_W-1:0] drive_q, drive_d;
  logic signed [DATA_W-1:0] iout_q, iout_d;
  logic                     hit_q, hit_d;

  // shared units
  logic                  mac_start, mac_busy;
  logic [MAC_A_W-1:0]    mac_a;
  logic [MAC_B_W-1:0]    mac_b;
  logic [MAC_R_W-1:0]    mac_res;
  logic                  div_start, div_busy;
  logic [DIV_N_W-1:0]    div_num;
  logic [DIV_Q_W-1:0]    div_quo;

  // error terms
  logic signed [MAG_W-1:0]  e_x, l_x, sum_e, dif_e;
  logic                     e_neg, sum_neg, dif_neg;
  logic [DATA_W-1:0]        e_mag;
  logic [MAG_W-1:0]         sum_mag, dif_mag;

  // clamp helpers
  logic signed [IRAW_W-1:0] iraw, ilim;
  logic signed [PI_W-1:0]   p_s;
  logic signed [TOT_W-1:0]  d_s, tlim;

  assign e_x     = {e_q[DATA_W-1], e_q};
  assign l_x     = {last_q[DATA_W-1], last_q};
  assign sum_e   = e_x + l_x;
  assign dif_e   = e_x - l_x;
  assign e_neg   = e_q[DATA_W-1];
  assign sum_neg = sum_e[MAG_W-1];
  assign dif_neg = dif_e[MAG_W-1];
  assign e_mag   = e_neg ? DATA_W'(-e_q) : DATA_W'(e_q);
  assign sum_mag = sum_neg ? MAG_W'(-sum_e) : MAG_W'(sum_e);
  assign dif_mag = dif_neg ? MAG_W'(-dif_e) : MAG_W'(dif_e);

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_load = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_gain_q <= '0;
      i_gain_q <= '0;
      d_gain_q <= '0;
      period_q <= PERIOD_RST;
      lim_q    <= LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_P_GAIN: p_gain_q <= cfg_data_i;
        CFG_I_GAIN: i_gain_q <= cfg_data_i;
        CFG_D_GAIN: d_gain_q <= cfg_data_i;
        CFG_PERIOD: period_q <= cfg_data_i;
        CFG_LIMIT:  lim_q    <= cfg_data_i[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (st_q)
      S_IDLE:     st_d = in_acc ? S_D_START : S_IDLE;
      S_D_START:  st_d = S_D_WAIT;
      S_D_WAIT:   st_d = mac_busy ? S_D_WAIT : S_P_WAIT;
      S_P_WAIT:   st_d = mac_busy ? S_P_WAIT : S_I1_WAIT;
      S_I1_WAIT:  st_d = mac_busy ? S_I1_WAIT : S_I2_WAIT;
      S_I2_WAIT:  st_d = mac_busy ? S_I2_WAIT : S_I_CLAMP;
      S_I_CLAMP:  st_d = S_SUM1;
      S_SUM1:     st_d = S_DIV_WAIT;
      S_DIV_WAIT: st_d = div_busy ? S_DIV_WAIT : S_SUM2;
      S_SUM2:     st_d = S_OUT;
      S_OUT:      st_d = out_load ? S_IDLE : S_OUT;
      default:    st_d = S_IDLE;
    endcase
  end

  always_comb begin
    mac_start = 1'b0;
    mac_a     = '0;
    mac_b     = '0;
    div_start = 1'b0;
    div_num   = {mac_res[DIV_N_W-2:0], 1'b0};
    pmag_d    = pmag_q;
    imag_d    = imag_q;
    iterm_d   = iterm_q;
    pi_d      = pi_q;
    tot_d     = tot_q;

    iraw  = IRAW_W'(iacc_q) + (sum_neg ? -IRAW_W'(imag_q) : IRAW_W'(imag_q));
    ilim  = IRAW_W'(lim_q);
    p_s   = e_neg ? -PI_W'(pmag_q) : PI_W'(pmag_q);
    d_s   = dif_neg ? -TOT_W'(div_quo) : TOT_W'(div_quo);
    tlim  = TOT_W'(lim_q);

    unique case (st_q)
      S_D_START: begin
        mac_start = 1'b1;
        mac_a     = MAC_A_W'(dif_mag);
        mac_b     = d_gain_q;
      end
      S_D_WAIT: begin
        if (!mac_busy) begin
          div_start = 1'b1;
          mac_start = 1'b1;
          mac_a     = MAC_A_W'(e_mag);
          mac_b     = p_gain_q;
        end
      end
      S_P_WAIT: begin
        if (!mac_busy) begin
          pmag_d    = mac_res[PMAG_W+15:16];
          mac_start = 1'b1;
          mac_a     = MAC_A_W'(sum_mag);
          mac_b     = i_gain_q;
        end
      end
      S_I1_WAIT: begin
        if (!mac_busy) begin
          mac_start = 1'b1;
          mac_a     = mac_res[MAC_A_W+15:16];
          mac_b     = period_q;
        end
      end
      S_I2_WAIT: begin
        if (!mac_busy) begin
          if ((|mac_res[MAC_R_W-1:IMAG_W+17]) ||
              (mac_res[IMAG_W+16] && (|mac_res[IMAG_W+15:17]))) begin
            imag_d = I_CAP;
          end else begin
            imag_d = mac_res[IMAG_W+16:17];
          end
        end
      end
      S_I_CLAMP: begin
        if (iraw > ilim) begin
          iterm_d = DATA_W'(ilim);
        end else if (iraw < -ilim) begin
          iterm_d = DATA_W'(-ilim);
        end else begin
          iterm_d = DATA_W'(iraw);
        end
      end
      S_SUM1:  pi_d  = p_s + PI_W'(iterm_q);
      S_SUM2:  tot_d = TOT_W'(pi_q) + d_s;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    drive_d     = drive_q;
    iout_d      = iout_q;
    hit_d       = hit_q;
    if ((st_q == S_OUT) && out_load) begin
      out_valid_d = 1'b1;
      iout_d      = iterm_q;
      if (tot_q > tlim) begin
        drive_d = DATA_W'(tlim);
        hit_d   = 1'b1;
      end else if (tot_q < -tlim) begin
        drive_d = DATA_W'(-tlim);
        hit_d   = 1'b1;
      end else begin
        drive_d = DATA_W'(tot_q);
        hit_d   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      out_valid_q <= 1'b0;
      last_q      <= '0;
      iacc_q      <= '0;
    end else begin
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
      if ((st_q == S_OUT) && out_load) begin
        last_q <= clr_q ? '0 : e_q;
        iacc_q <= clr_q ? '0 : iterm_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      e_q   <= error_value_i;
      clr_q <= clear_after_i;
    end
    pmag_q  <= pmag_d;
    imag_q  <= imag_d;
    iterm_q <= iterm_d;
    pi_q    <= pi_d;
    tot_q   <= tot_d;
    drive_q <= drive_d;
    iout_q  <= iout_d;
    hit_q   <= hit_d;
  end

  psaw_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mac_start),
    .a_i     (mac_a),
    .b_i     (mac_b),
    .busy_o  (mac_busy),
    .res_o   (mac_res)
  );

  psaw_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (period_q),
    .busy_o  (div_busy),
    .quo_o   (div_quo)
  );

  assign in_stall_o       = (st_q != S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign drive_o          = drive_q;
  assign integral_term_o  = iout_q;
  assign output_clamped_o = hit_q;

endmodule

`default_nettype wire

// ===== rtl/psaw_checker.sv =====
// Port-level checker for the PID anti-windup block, bound to the top level.
`default_nettype none

module psaw_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            in_valid_i,
  input wire logic                            in_stall_o,
  input wire logic                            out_valid_o,
  input wire logic                            out_stall_i,
  input wire logic [psaw_pkg::DATA_W-1:0]     drive_o,
  input wire logic [psaw_pkg::DATA_W-1:0]     integral_term_o,
  input wire logic                            output_clamped_o
);
  import psaw_pkg::*;

  localparam logic [DATA_W-1:0] MOST_NEG = {1'b1, {(DATA_W-1){1'b0}}};

  // an accepted transaction keeps the block busy for the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again straight after a transaction");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(drive_o) &&
      $stable(integral_term_o) && $stable(output_clamped_o))
    else $error("stalled result changed");

  // a new result only appears as the sequencer finishes an item
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared while idle");

  // symmetric clamp never yields the most negative code
  a_clamp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (drive_o != MOST_NEG) && (integral_term_o != MOST_NEG))
    else $error("result outside symmetric range");

endmodule

bind pid_step_antiwindup psaw_checker u_psaw_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .drive_o          (drive_o),
  .integral_term_o  (integral_term_o),
  .output_clamped_o (output_clamped_o)
);

`default_nettype wire

// ===== bench/tb_pid_step_antiwindup.sv =====
// Testbench: random and directed error samples checked against a PID model with clamping.
`timescale 1ns / 1ps

module tb_pid_step_antiwindup;

  typedef struct packed {
    logic signed [31:0] err;
    logic               clr;
  } err_sample_t;

  typedef struct packed {
    logic signed [31:0] drive;
    logic signed [31:0] integ;
    logic               clamped;
  } ctrl_out_t;

  localparam logic [31:0]     E_MAX         = 32'h7FFF_FFFF;
  localparam logic [31:0]     E_MIN         = 32'h8000_0000;
  localparam logic [31:0]     WORD_MAX      = 32'hFFFF_FFFF;
  localparam logic [31:0]     DEF_PERIOD    = 32'd262;
  localparam logic [30:0]     DEF_LIMIT     = 31'd26214400;
  localparam logic [31:0]     ONE_Q16       = 32'h0001_0000;
  localparam longint unsigned INT_STEP_CAP  = 64'h0000_0100_0000_0000;
  localparam longint unsigned DERIV_CAP     = 64'h0001_0000_0000_0000;

  logic                                    clk_i;
  logic                                    rst_ni        = 1'b0;
  logic                                    cfg_we_i      = 1'b0;
  logic [psaw_pkg::CFG_IDX_W-1:0]          cfg_index_i   = '0;
  logic [psaw_pkg::DATA_W-1:0]             cfg_data_i    = '0;
  logic                                    in_valid_i    = 1'b0;
  logic                                    in_stall_o;
  logic signed [psaw_pkg::DATA_W-1:0]      error_value_i = '0;
  logic                                    clear_after_i = 1'b0;
  logic                                    out_valid_o;
  logic                                    out_stall_i   = 1'b0;
  logic signed [psaw_pkg::DATA_W-1:0]      drive_o;
  logic signed [psaw_pkg::DATA_W-1:0]      integral_term_o;
  logic                                    output_clamped_o;

  pid_step_antiwindup u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .error_value_i    (error_value_i),
    .clear_after_i    (clear_after_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .drive_o          (drive_o),
    .integral_term_o  (integral_term_o),
    .output_clamped_o (output_clamped_o)
  );

  // mirrored configuration and controller state
  logic [31:0] kp, ki, kd, period;
  logic [30:0] limit;
  longint      prev_err, integ_acc;

  err_sample_t error_q[$];
  ctrl_out_t   ctrl_out_q[$];
  bit          in_fired    = 1'b0;
  int          idle_pct    = 34;
  int          mismatches  = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic report_mismatch(string what);
    $display("%0t ns: mismatch: %s", $time, what);
    mismatches++;
  endtask

  function automatic longint unsigned magnitude(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint with_sign(longint s, longint unsigned m);
    return (s < 0) ? -$signed(m) : $signed(m);
  endfunction

  function automatic void reset_model();
    kp        = '0;
    ki        = '0;
    kd        = '0;
    period    = DEF_PERIOD;
    limit     = DEF_LIMIT;
    prev_err  = 0;
    integ_acc = 0;
  endfunction

  function automatic void apply_reg(logic [psaw_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
    case (idx)
      psaw_pkg::CFG_P_GAIN: kp     = data;
      psaw_pkg::CFG_I_GAIN: ki     = data;
      psaw_pkg::CFG_D_GAIN: kd     = data;
      psaw_pkg::CFG_PERIOD: period = data;
      psaw_pkg::CFG_LIMIT:  limit  = data[30:0];
      default: ;
    endcase
  endfunction

  function automatic ctrl_out_t pid_compute(logic signed [31:0] err, logic clr);
    longint          e, lim, sum_e, dif_e, p_term, i_term, d_term, total;
    longint unsigned g, t, m, x, q, r;
    logic [127:0]    wide;
    logic            hit;
    ctrl_out_t       res;
    e     = err;
    lim   = {33'd0, limit};
    t     = {32'd0, period};
    sum_e = e + prev_err;
    dif_e = e - prev_err;

    g      = {32'd0, kp};
    m      = (g * magnitude(e)) >> 16;
    p_term = with_sign(e, m);

    // trapezoid step, product saturated at 64 bits before the shift
    g    = {32'd0, ki};
    x    = (g * magnitude(sum_e)) >> 16;
    wide = {64'd0, x} * {64'd0, t};
    m    = (wide[127:64] != 0) ? {64{1'b1}} : wide[63:0];
    m    = m >> 17;
    if (m > INT_STEP_CAP) m = INT_STEP_CAP;
    i_term = integ_acc + with_sign(sum_e, m);
    if (i_term > lim) i_term = lim;
    else if (i_term < -lim) i_term = -lim;

    // 2*x/T rounded down, built from the quotient and remainder of x/T
    g = {32'd0, kd};
    x = g * magnitude(dif_e);
    if (t == 0) begin
      m = (x != 0) ? DERIV_CAP : 64'd0;
    end else begin
      q = x / t;
      r = x % t;
      if (q > DERIV_CAP / 2) m = DERIV_CAP;
      else m = 64'd2 * q + ((64'd2 * r >= t) ? 64'd1 : 64'd0);
      if (m > DERIV_CAP) m = DERIV_CAP;
    end
    d_term = with_sign(dif_e, m);

    total = p_term + i_term + d_term;
    hit   = 1'b1;
    if (total > lim) total = lim;
    else if (total < -lim) total = -lim;
    else hit = 1'b0;

    res.drive   = total[31:0];
    res.integ   = i_term[31:0];
    res.clamped = hit;
    if (clr) begin
      prev_err  = 0;
      integ_acc = 0;
    end else begin
      prev_err  = e;
      integ_acc = i_term;
    end
    return res;
  endfunction

  function automatic logic signed [31:0] pick_error();
    logic [31:0] v;
    int unsigned sel;
    v   = $urandom;
    sel = $urandom_range(99);
    if (sel < 40) begin
      v = {{14{v[17]}}, v[17:0]};
    end else if (sel < 55) begin
      v = {{7{v[24]}}, v[24:0]};
    end else if (sel < 70) begin
      case ($urandom_range(4))
        0: v = E_MAX;
        1: v = E_MIN;
        2: v = '0;
        3: v = 32'd1;
        default: v = WORD_MAX;
      endcase
    end
    return v;
  endfunction

  function automatic logic [31:0] rand_cfg(logic [psaw_pkg::CFG_IDX_W-1:0] idx);
    logic [31:0] v;
    int unsigned sel;
    v   = $urandom;
    sel = $urandom_range(3);
    if (idx == psaw_pkg::CFG_PERIOD) begin
      case (sel)
        0: v = 32'd1;
        1: v = WORD_MAX;
        2: v = $urandom_range(32'h4000, 1);
        default: ;
      endcase
    end else if (idx == psaw_pkg::CFG_LIMIT) begin
      case (sel)
        0: v[30:0] = '1;
        1: v[30:0] = 31'($urandom_range(32'h0FFF_FFFF));
        2: v[30:0] = 31'($urandom_range(32'h00FF_FFFF));
        default: ;
      endcase
    end else begin
      case (sel)
        0: v = '0;
        1: v = $urandom_range(32'h4_0000);
        2: v = $urandom_range(32'h1000);
        default: ;
      endcase
    end
    return v;
  endfunction

  function automatic void push_sample(logic signed [31:0] e, logic c);
    err_sample_t s;
    s.err = e;
    s.clr = c;
    error_q.push_back(s);
  endfunction

  task automatic write_reg(logic [psaw_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
  endtask

  task automatic wait_drained();
    @(posedge clk_i);
    while (error_q.size() != 0 || in_valid_i || ctrl_out_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic run_phase(logic [31:0] p_v, logic [31:0] i_v, logic [31:0] d_v,
                           logic [31:0] t_v, logic [31:0] lim_v, int n_rand, bit directed);
    logic [psaw_pkg::CFG_IDX_W-1:0] spare_idx;
    int k;
    write_reg(psaw_pkg::CFG_P_GAIN, p_v);
    write_reg(psaw_pkg::CFG_I_GAIN, i_v);
    write_reg(psaw_pkg::CFG_D_GAIN, d_v);
    write_reg(psaw_pkg::CFG_PERIOD, t_v);
    write_reg(psaw_pkg::CFG_LIMIT, lim_v);
    if ($urandom_range(1) == 1) begin
      // unmapped index: must be ignored
      spare_idx = psaw_pkg::CFG_LIMIT + 3'd1 + 3'($urandom_range(2));
      write_reg(spare_idx, $urandom);
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (directed) begin
      push_sample('0, 1'b0);
      push_sample(32'sd1, 1'b0);
      push_sample(-32'sd1, 1'b0);
      push_sample(E_MAX, 1'b0);
      push_sample(E_MAX, 1'b0);
      push_sample(E_MIN, 1'b0);
      push_sample(E_MIN, 1'b0);
      push_sample(E_MAX, 1'b1);
      push_sample(ONE_Q16, 1'b0);
      push_sample(-32'sh0064_0000, 1'b0);
      push_sample(32'sh0190_0000, 1'b0);
      push_sample(-32'sd1, 1'b1);
    end
    for (k = 0; k < n_rand; k++) push_sample(pick_error(), $urandom_range(99) < 6);
    wait_drained();
  endtask

  // input acceptance, config mirror and result checking
  always @(posedge clk_i) begin : monitor
    ctrl_out_t want;
    in_fired = 1'b0;
    if (!rst_ni) begin
      reset_model();
    end else begin
      if (cfg_we_i) apply_reg(cfg_index_i, cfg_data_i);
      if (in_valid_i && !in_stall_o) begin
        in_fired = 1'b1;
        ctrl_out_q.push_back(pid_compute(error_value_i, clear_after_i));
      end
      if (out_valid_o && !out_stall_i) begin
        if (ctrl_out_q.size() == 0) begin
          report_mismatch("result transaction with nothing outstanding");
        end else begin
          want = ctrl_out_q.pop_front();
          if (drive_o !== want.drive)
            report_mismatch($sformatf("drive %0d, want %0d", drive_o, want.drive));
          if (integral_term_o !== want.integ)
            report_mismatch($sformatf("integral %0d, want %0d", integral_term_o, want.integ));
          if (output_clamped_o !== want.clamped)
            report_mismatch($sformatf("clamp flag %0b, want %0b",
                                      output_clamped_o, want.clamped));
        end
      end
    end
  end

  always @(negedge clk_i) begin : driver
    err_sample_t nxt;
    if (!in_valid_i || in_fired) begin
      if (rst_ni && error_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        nxt = error_q.pop_front();
        in_valid_i    <= 1'b1;
        error_value_i <= nxt.err;
        clear_after_i <= nxt.clr;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) out_stall_i <= rst_ni && ($urandom_range(99) < idle_pct);

  initial begin : stimulus
    int ph;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset configuration
    push_sample(pick_error(), 1'b0);
    push_sample(pick_error(), 1'b0);
    push_sample(pick_error(), 1'b0);
    wait_drained();

    run_phase(ONE_Q16, 32'h0000_8000, 32'h0000_0290, DEF_PERIOD, {1'b0, DEF_LIMIT}, 120, 1'b1);
    run_phase(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, 140, 1'b0);
    // zero period
    run_phase(32'h0002_0000, ONE_Q16, 32'h0000_0100, '0, E_MAX, 120, 1'b1);
    // zero limit
    run_phase(rand_cfg(psaw_pkg::CFG_P_GAIN), rand_cfg(psaw_pkg::CFG_I_GAIN),
              rand_cfg(psaw_pkg::CFG_D_GAIN), DEF_PERIOD, '0, 140, 1'b0);
    run_phase('0, WORD_MAX, '0, 32'd1, E_MAX, 140, 1'b0);

    idle_pct = 0;
    run_phase(32'h0000_4000, 32'h0004_0000, 32'h0000_0010, 32'h0000_1000,
              32'h0020_0000, 150, 1'b0);
    idle_pct = 34;

    for (ph = 0; ph < 8; ph++)
      run_phase(rand_cfg(psaw_pkg::CFG_P_GAIN), rand_cfg(psaw_pkg::CFG_I_GAIN),
                rand_cfg(psaw_pkg::CFG_D_GAIN), rand_cfg(psaw_pkg::CFG_PERIOD),
                rand_cfg(psaw_pkg::CFG_LIMIT), 140, 1'b0);

    repeat (64) @(posedge clk_i);
    if (ctrl_out_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", ctrl_out_q.size()));
    if (mismatches == 0) begin
      $display("tb_pid_step_antiwindup: PASS");
    end else begin
      $display("tb_pid_step_antiwindup: FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("tb_pid_step_antiwindup: FAIL");
    $finish;
  end

endmodule

// ===== pid_step_antiwindup.f =====
rtl/psaw_pkg.sv
rtl/psaw_mac.sv
rtl/psaw_div.sv
rtl/pid_step_antiwindup.sv
rtl/psaw_checker.sv
bench/tb_pid_step_antiwindup.sv
